/* hw/rtl/line_sensor_centroid_top_assert.svh */
// Assertion macros shared by the line sensor centroid RTL.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef LINE_SENSOR_CENTROID_TOP_ASSERT_SVH
`define LINE_SENSOR_CENTROID_TOP_ASSERT_SVH

// same-cycle implication
`define LSC_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define LSC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hw/rtl/lsc_pkg.sv */
// Shared types and constants of the line sensor centroid block.
// No dependencies; imported by lsc_ctrl, lsc_datapath and the top level.
package lsc_pkg;

	localparam int CFG_W     = 12;
	localparam int POS_W     = 16;
	localparam int CNT_W     = 5;
	localparam int ADDR_W    = 3;
	localparam int PDATA_W   = 32;
	localparam int DIV_CNT_W = $clog2(POS_W);

	localparam logic [CFG_W-1:0] THR_RESET  = 12'd2048;
	localparam logic [CFG_W-1:0] MULT_RESET = 12'd2048;
	localparam logic [POS_W-1:0] NO_LINE_POS = 16'h8000;
	localparam logic [POS_W-1:0] POS_MAX     = 16'hFFFF;
	localparam logic [CNT_W-1:0] COUNT_MAX   = 5'd31;

	// register index, taken from paddr[2]
	localparam logic REG_THRESHOLD = 1'b0;
	localparam logic REG_MULT      = 1'b1;

	typedef struct packed {
		logic [CFG_W-1:0] thr;
		logic [CFG_W-1:0] mult;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic lo_rd;
		logic lo_step;
		logic hi_rd;
		logic hi_step;
		logic ext_clr;
		logic ptr_lo;
		logic acc_rd;
		logic mul;
		logic div_init;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic scan_last;
		logic lo_can;
		logic lo_less;
		logic hi_can;
		logic hi_less;
		logic acc_last;
		logic div_last;
		logic out_free;
	} sts_t;

endpackage

/* hw/rtl/lsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsc_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/lsc_ctrl.sv */
// Sequencer of the line sensor centroid: load, scan, widen, sum, multiply, divide, output.
// Depends on lsc_pkg and line_sensor_centroid_top_assert.svh.
`include "line_sensor_centroid_top_assert.svh"

module lsc_ctrl
	import lsc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	input  logic frame_last,
	output logic sample_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [12:0] {
		ST_LOAD     = 13'b0000000000001,
		ST_SCAN     = 13'b0000000000010,
		ST_SCAN_END = 13'b0000000000100,
		ST_LO_RD    = 13'b0000000001000,
		ST_LO_CHK   = 13'b0000000010000,
		ST_HI_RD    = 13'b0000000100000,
		ST_HI_CHK   = 13'b0000001000000,
		ST_ACC      = 13'b0000010000000,
		ST_ACC_END  = 13'b0000100000000,
		ST_MUL      = 13'b0001000000000,
		ST_DIV_INIT = 13'b0010000000000,
		ST_DIV      = 13'b0100000000000,
		ST_FINISH   = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign sample_stall = (state_q != ST_LOAD);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load = sample_valid;
				if (sample_valid && frame_last) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			ST_SCAN_END: begin
				state_d = ST_LO_RD;
			end
			ST_LO_RD: begin
				if (!sts.found) begin
					state_d = ST_FINISH;
				end else if (sts.lo_can) begin
					cmd.lo_rd = 1'b1;
					state_d   = ST_LO_CHK;
				end else begin
					cmd.ext_clr = 1'b1;
					state_d     = ST_HI_RD;
				end
			end
			ST_LO_CHK: begin
				if (sts.lo_less) begin
					cmd.lo_step = 1'b1;
					state_d     = ST_LO_RD;
				end else begin
					cmd.ext_clr = 1'b1;
					state_d     = ST_HI_RD;
				end
			end
			ST_HI_RD: begin
				if (sts.hi_can) begin
					cmd.hi_rd = 1'b1;
					state_d   = ST_HI_CHK;
				end else begin
					cmd.ptr_lo = 1'b1;
					state_d    = ST_ACC;
				end
			end
			ST_HI_CHK: begin
				if (sts.hi_less) begin
					cmd.hi_step = 1'b1;
					state_d     = ST_HI_RD;
				end else begin
					cmd.ptr_lo = 1'b1;
					state_d    = ST_ACC;
				end
			end
			ST_ACC: begin
				cmd.acc_rd = 1'b1;
				if (sts.acc_last) begin
					state_d = ST_ACC_END;
				end
			end
			ST_ACC_END: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	`LSC_ASSERT_NEXT(a_last_starts_scan, sample_valid && !sample_stall && frame_last, state_q == ST_SCAN, "frame end did not start the scan")

endmodule

/* hw/rtl/lsc_datapath.sv */
// Datapath of the line sensor centroid: sample RAM, scan, window, sums, multiplier, divider.
// Depends on lsc_pkg, lsc_ram and line_sensor_centroid_top_assert.svh.
`include "line_sensor_centroid_top_assert.svh"

module lsc_datapath
	import lsc_pkg::*;
#(
	parameter int NUM_SENSORS  = 32,
	parameter int SAMPLE_BITS  = 12,
	parameter int EXTEND_LIMIT = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [11:0]      sensor_value,
	input  logic             frame_last,
	input  logic             result_stall,
	output logic             result_valid,
	output logic [POS_W-1:0] line_position,
	output logic [CNT_W-1:0] line_count,
	output logic             line_found
);

	localparam int IDX_W  = $clog2(NUM_SENSORS);
	localparam int LD_W   = $clog2(NUM_SENSORS + 1);
	localparam int EXT_W  = $clog2(EXTEND_LIMIT + 2);
	localparam int SB     = SAMPLE_BITS;
	localparam int SUM_W  = SB + $clog2(NUM_SENSORS + 1);
	localparam int TERM_W = IDX_W + SB;
	localparam int WSUM_W = SB + 2 * IDX_W;
	localparam int PROD_W = WSUM_W + CFG_W;
	localparam int CMP_W  = (PROD_W > SUM_W + POS_W) ? PROD_W : SUM_W + POS_W;
	localparam int THRC_W = (SB > CFG_W) ? SB : CFG_W;

	logic [LD_W-1:0]      ld_idx_q;
	logic [IDX_W-1:0]     ptr_q;
	logic [IDX_W-1:0]     idx_s1;
	logic                 rd_scan_s1, rd_acc_s1;
	logic                 found_q, prev_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [EXT_W-1:0]     ext_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic                 out_valid_q;

	logic [IDX_W-1:0]     lo_q, hi_q;
	logic [SB-1:0]        lo_val_q, hi_val_q;
	logic [WSUM_W-1:0]    wsum_q;
	logic [SUM_W-1:0]     sum_q;
	logic [PROD_W-1:0]    prod_q;
	logic [SUM_W-1:0]     rem_q;
	logic [POS_W-1:0]     num_q;
	logic                 sat_q;
	logic [POS_W-1:0]     pos_q;
	logic [CNT_W-1:0]     lcnt_q;
	logic                 lfound_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     raddr;
	logic [SB-1:0]        rdata;
	logic                 is_high;
	logic [TERM_W-1:0]    term;
	logic [SUM_W:0]       trial;
	logic                 trial_ge;
	logic                 sat_d;
	logic                 frame_start;

	assign ram_we      = cmd.load && (ld_idx_q < LD_W'(NUM_SENSORS));
	assign frame_start = cmd.load && frame_last;

	always_comb begin
		priority if (cmd.lo_rd) begin
			raddr = lo_q - IDX_W'(1);
		end else if (cmd.hi_rd) begin
			raddr = hi_q + IDX_W'(1);
		end else begin
			raddr = ptr_q;
		end
	end

	lsc_ram #(
		.WIDTH (SB),
		.DEPTH (NUM_SENSORS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ld_idx_q[IDX_W-1:0]),
		.wdata (SB'(sensor_value)),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign is_high  = THRC_W'(rdata) > THRC_W'(cfg.thr);
	assign term     = TERM_W'(idx_s1) * TERM_W'(rdata);
	assign trial    = {rem_q, num_q[POS_W-1]};
	assign trial_ge = trial >= (SUM_W + 1)'(sum_q);
	assign sat_d    = CMP_W'(prod_q) >= (CMP_W'(sum_q) << POS_W);

	assign sts.found     = found_q;
	assign sts.scan_last = (ptr_q == IDX_W'(NUM_SENSORS - 1));
	assign sts.lo_can    = (lo_q != '0) && (ext_q < EXT_W'(EXTEND_LIMIT));
	assign sts.lo_less   = rdata < lo_val_q;
	assign sts.hi_can    = (hi_q != IDX_W'(NUM_SENSORS - 1)) && (ext_q < EXT_W'(EXTEND_LIMIT));
	assign sts.hi_less   = rdata < hi_val_q;
	assign sts.acc_last  = (ptr_q == hi_q);
	assign sts.div_last  = (div_cnt_q == DIV_CNT_W'(POS_W - 1));
	assign sts.out_free  = !out_valid_q || !result_stall;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_idx_q    <= '0;
			ptr_q       <= '0;
			rd_scan_s1  <= 1'b0;
			rd_acc_s1   <= 1'b0;
			found_q     <= 1'b0;
			prev_q      <= 1'b0;
			cnt_q       <= '0;
			ext_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_scan_s1 <= cmd.scan_rd;
			rd_acc_s1  <= cmd.acc_rd;
			if (cmd.load) begin
				if (frame_last) begin
					ld_idx_q <= '0;
				end else if (ram_we) begin
					ld_idx_q <= ld_idx_q + LD_W'(1);
				end
			end
			if (frame_start) begin
				ptr_q   <= '0;
				found_q <= 1'b0;
				prev_q  <= 1'b0;
				cnt_q   <= '0;
				ext_q   <= '0;
			end
			if (cmd.scan_rd || cmd.acc_rd) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
			if (cmd.ptr_lo) begin
				ptr_q <= lo_q;
			end
			if (rd_scan_s1) begin
				prev_q <= is_high;
				if (is_high) begin
					found_q <= 1'b1;
				end
				if (is_high && !prev_q && cnt_q < COUNT_MAX) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (cmd.lo_step || cmd.hi_step) begin
				ext_q <= ext_q + EXT_W'(1);
			end
			if (cmd.ext_clr) begin
				ext_q <= '0;
			end
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= ptr_q;
		if (frame_start) begin
			wsum_q <= '0;
			sum_q  <= '0;
		end
		if (rd_scan_s1 && is_high) begin
			if (!found_q) begin
				lo_q     <= idx_s1;
				lo_val_q <= rdata;
			end
			hi_q     <= idx_s1;
			hi_val_q <= rdata;
		end
		if (cmd.lo_step) begin
			lo_q     <= lo_q - IDX_W'(1);
			lo_val_q <= rdata;
		end
		if (cmd.hi_step) begin
			hi_q     <= hi_q + IDX_W'(1);
			hi_val_q <= rdata;
		end
		if (rd_acc_s1) begin
			wsum_q <= wsum_q + WSUM_W'(term);
			sum_q  <= sum_q + SUM_W'(rdata);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(wsum_q) * PROD_W'(cfg.mult);
		end
		if (cmd.div_init) begin
			sat_q <= sat_d;
			rem_q <= SUM_W'(prod_q >> POS_W);
			num_q <= prod_q[POS_W-1:0];
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? SUM_W'(trial - (SUM_W + 1)'(sum_q)) : SUM_W'(trial);
			num_q <= {num_q[POS_W-2:0], trial_ge};
		end
		if (cmd.out_load) begin
			lfound_q <= found_q;
			lcnt_q   <= cnt_q;
			if (!found_q) begin
				pos_q <= NO_LINE_POS;
			end else if (sat_q) begin
				pos_q <= POS_MAX;
			end else begin
				pos_q <= num_q;
			end
		end
	end

	assign result_valid  = out_valid_q;
	assign line_position = pos_q;
	assign line_count    = lcnt_q;
	assign line_found    = lfound_q;

	`LSC_ASSERT_NOW(a_acc_in_window, cmd.acc_rd, (ptr_q >= lo_q) && (ptr_q <= hi_q), "sum read outside window")
	`LSC_ASSERT_NOW(a_lo_not_zero, cmd.lo_rd, lo_q != '0, "widening read below sensor 0")
	`LSC_ASSERT_NOW(a_div_rem, cmd.div_step && !sat_q, rem_q < sum_q, "divider remainder out of range")

endmodule

/* hw/rtl/line_sensor_centroid_top.sv */
// Top level of the line sensor centroid block: APB registers, controller, datapath.
// Depends on lsc_pkg, lsc_ctrl, lsc_datapath (and lsc_ram below it).
//
// Usage: samples enter on the sample channel (sensor_value, frame_last), one word
// per cycle in sensor index order while sample_stall is low. The word with
// frame_last set closes the frame; only it produces a result word on the result
// channel (line_position, line_count, line_found).
// After the frame end the block stalls the sample channel while it evaluates the
// frame, reading the sample RAM through its single read port: a scan of all
// NUM_SENSORS samples, up to EXTEND_LIMIT widening steps per side while the next
// sample is lower, a sum over the window, a multiply, a divider init, 16
// restoring divider steps and an output step. With no line found the block
// goes from the scan straight to the output step.
// A result waits in the output register while result_stall is high; the next
// frame is loaded meanwhile and its evaluation holds in its last step until the
// register is free.
// Reset clears the controller, the load index and the output valid, and loads
// the register reset values. The sample RAM is not cleared.
// Registers: high_threshold at 0x0, position_multiplier at 0x4, 12 bits each.
module line_sensor_centroid_top
	import lsc_pkg::*;
#(
	parameter int NUM_SENSORS  = 32,
	parameter int SAMPLE_BITS  = 12,
	parameter int EXTEND_LIMIT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic [11:0]        sensor_value,
	input  logic               frame_last,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [POS_W-1:0]   line_position,
	output logic [CNT_W-1:0]   line_count,
	output logic               line_found
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr  <= THR_RESET;
			cfg_q.mult <= MULT_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_THRESHOLD: cfg_q.thr  <= pwdata[CFG_W-1:0];
				REG_MULT:      cfg_q.mult <= pwdata[CFG_W-1:0];
				default:       cfg_q      <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_THRESHOLD: prdata = PDATA_W'(cfg_q.thr);
			REG_MULT:      prdata = PDATA_W'(cfg_q.mult);
			default:       prdata = '0;
		endcase
	end

	lsc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.frame_last   (frame_last),
		.sample_stall (sample_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	lsc_datapath #(
		.NUM_SENSORS  (NUM_SENSORS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.EXTEND_LIMIT (EXTEND_LIMIT)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.sts           (sts),
		.sensor_value  (sensor_value),
		.frame_last    (frame_last),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.line_position (line_position),
		.line_count    (line_count),
		.line_found    (line_found)
	);

endmodule

/* dv/tb_line_sensor_centroid_top.sv */
// Self-checking testbench for line_sensor_centroid_top: frames of sensor samples are
// streamed in, every result word is checked against an in-bench centroid predictor.
// Depends on lsc_pkg and the line_sensor_centroid_top RTL.
module tb_line_sensor_centroid_top;
	timeunit 1ns;
	timeprecision 1ps;
	import lsc_pkg::*;

	localparam int NUM_SENSORS    = 32;
	localparam int EXTEND_LIMIT   = 2;
	localparam int SAMPLE_W       = 12;
	localparam int SETTLE_CYCLES  = 2 * NUM_SENSORS + 48;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 1550;
	localparam int NUM_PHASES     = 6;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                last;
	} sample_word_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] cnt;
		logic             found;
	} line_result_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [ADDR_W-1:0]  paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic               sample_valid = 1'b0;
	logic [11:0]        sensor_value = '0;
	logic               frame_last   = 1'b0;
	logic               result_stall = 1'b0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               sample_stall;
	logic               result_valid;
	logic [POS_W-1:0]   line_position;
	logic [CNT_W-1:0]   line_count;
	logic               line_found;

	line_sensor_centroid_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.sample_valid  (sample_valid),
		.sample_stall  (sample_stall),
		.sensor_value  (sensor_value),
		.frame_last    (frame_last),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.line_position (line_position),
		.line_count    (line_count),
		.line_found    (line_found)
	);

	always #1ns clk = ~clk;

	// centroid predictor state
	logic [SAMPLE_W-1:0] sample_mem [NUM_SENSORS];
	int unsigned         load_ptr = 0;
	logic [CFG_W-1:0]    thr_cfg  = THR_RESET;
	logic [CFG_W-1:0]    mult_cfg = MULT_RESET;
	line_result_t        expected_lines[$];
	sample_word_t        pending_samples[$];

	int unsigned frames_sent  = 0;
	int unsigned samples_in   = 0;
	int unsigned results_seen = 0;
	int unsigned lines_found  = 0;
	int unsigned mismatches   = 0;

	function automatic line_result_t compute_line_result();
		line_result_t      r;
		int                first, last, lo, hi, runs;
		bit                prev;
		longint unsigned   wsum, sum, pos;
		first = -1;
		last  = -1;
		runs  = 0;
		prev  = 1'b0;
		wsum  = 0;
		sum   = 0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			if (sample_mem[i] > thr_cfg) begin
				if (first < 0)
					first = i;
				last = i;
				if (!prev && runs < COUNT_MAX)
					runs++;
				prev = 1'b1;
			end else begin
				prev = 1'b0;
			end
		end
		if (first < 0) begin
			r.pos   = NO_LINE_POS;
			r.cnt   = '0;
			r.found = 1'b0;
			return r;
		end
		lo = first;
		while (lo > 0 && first - lo < EXTEND_LIMIT && sample_mem[lo-1] < sample_mem[lo])
			lo--;
		hi = last;
		while (hi < NUM_SENSORS - 1 && hi - last < EXTEND_LIMIT &&
				sample_mem[hi+1] < sample_mem[hi])
			hi++;
		for (int i = lo; i <= hi; i++) begin
			wsum += longint'(i) * sample_mem[i];
			sum  += sample_mem[i];
		end
		pos = (sum != 0) ? (wsum * mult_cfg) / sum : 0;
		if (pos > POS_MAX)
			pos = 64'(POS_MAX);
		r.pos   = pos[POS_W-1:0];
		r.cnt   = runs[CNT_W-1:0];
		r.found = 1'b1;
		return r;
	endfunction

	function automatic void accept_sample(input sample_word_t wd);
		if (load_ptr < NUM_SENSORS) begin
			sample_mem[load_ptr] = wd.value;
			load_ptr++;
		end
		if (wd.last) begin
			load_ptr = 0;
			expected_lines.push_back(compute_line_result());
		end
	endfunction

	// sample driver: bursts of random length, random gaps
	sample_word_t cur_word;
	int           burst_left = 0;
	int           gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				accept_sample(cur_word);
				samples_in++;
			end
			if (!sample_valid || !sample_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					cur_word = pending_samples.pop_front();
					sensor_value <= cur_word.value;
					frame_last   <= cur_word.last;
					sample_valid <= 1'b1;
					if (burst_left == 0) begin
						if ($urandom_range(4, 0) == 0) begin
							burst_left = $urandom_range(300, 100);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(24, 1);
							gap_left   = $urandom_range(6, 1);
						end
					end else begin
						burst_left--;
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall pattern
	int unsigned stall_cnt  = 0;
	int          stall_mode = 0;

	always @(posedge clk) begin
		line_result_t got, want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				got.pos   = line_position;
				got.cnt   = line_count;
				got.found = line_found;
				results_seen++;
				if (expected_lines.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result word pos=%h cnt=%0d found=%0b",
							$realtime, got.pos, got.cnt, got.found);
				end else begin
					want = expected_lines.pop_front();
					if (want.found)
						lines_found++;
					if (got.pos !== want.pos || got.cnt !== want.cnt ||
							got.found !== want.found) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch pos exp=%h act=%h cnt exp=%0d act=%0d found exp=%0b act=%0b",
								$realtime, want.pos, got.pos, want.cnt, got.cnt,
								want.found, got.found);
					end
				end
			end
			stall_cnt++;
			if (stall_cnt % 64 == 0)
				stall_mode = $urandom_range(3, 0);
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(3, 0) == 0);
				2: result_stall <= ($urandom_range(3, 0) != 0);
				default: result_stall <= stall_cnt[2];
			endcase
		end
	end

	// watchdog on cycles without any accepted word
	int unsigned idle_cycles = 0;

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("line_sensor_centroid_top verification failed");
			$finish;
		end
	end

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == REG_THRESHOLD)
			thr_cfg = val;
		else
			mult_cfg = val;
	endtask

	task automatic wait_drained();
		while (pending_samples.size() != 0 || sample_valid || expected_lines.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_frame(input logic [SAMPLE_W-1:0] v [NUM_SENSORS], input int len);
		sample_word_t wd;
		for (int i = 0; i < len; i++) begin
			wd.value = (i < NUM_SENSORS) ? v[i] : SAMPLE_W'($urandom_range(4095, 0));
			wd.last  = (i == len - 1);
			pending_samples.push_back(wd);
		end
		frames_sent++;
	endtask

	// line profile: lows at or under threshold, high runs with falling shoulders; uniform frames are random throughout
	task automatic queue_frame(input int len, input bit uniform);
		logic [SAMPLE_W-1:0] v [NUM_SENSORS];
		int                  t, c, w, nlines;
		t = int'(thr_cfg);
		for (int i = 0; i < NUM_SENSORS; i++)
			v[i] = uniform ? SAMPLE_W'($urandom_range(4095, 0)) :
				SAMPLE_W'($urandom_range(t, 0));
		if (!uniform && t < 4095) begin
			nlines = $urandom_range(3, 0);
			repeat (nlines) begin
				c = $urandom_range(NUM_SENSORS - 1, 0);
				w = $urandom_range(4, 1);
				for (int j = c; j < c + w && j < NUM_SENSORS; j++)
					v[j] = SAMPLE_W'($urandom_range(4095, t + 1));
				if (c >= 1)
					v[c-1] = SAMPLE_W'($urandom_range(t, t / 2));
				if (c >= 2)
					v[c-2] = SAMPLE_W'($urandom_range(t / 2, 0));
				if (c + w < NUM_SENSORS)
					v[c+w] = SAMPLE_W'($urandom_range(t, t / 2));
				if (c + w + 1 < NUM_SENSORS)
					v[c+w+1] = SAMPLE_W'($urandom_range(t / 2, 0));
			end
		end
		push_frame(v, len);
	endtask

	task automatic queue_random_frames(input int budget);
		int count, len, r;
		count = 0;
		while (count < budget) begin
			r = $urandom_range(99, 0);
			if (r < 70)
				len = NUM_SENSORS;
			else if (r < 80)
				len = $urandom_range(NUM_SENSORS - 1, 1);
			else if (r < 90)
				len = $urandom_range(NUM_SENSORS + 8, NUM_SENSORS + 1);
			else
				len = NUM_SENSORS;
			queue_frame(len, r >= 90);
			count += (len > NUM_SENSORS) ? NUM_SENSORS : len;
		end
	endtask

	// full frame with runs at both ends, a sample at threshold, then a one-word frame
	task automatic queue_directed();
		logic [SAMPLE_W-1:0] v [NUM_SENSORS];
		for (int i = 0; i < NUM_SENSORS; i++)
			v[i] = '0;
		v[0]  = 12'd4095;
		v[1]  = THR_RESET;
		v[2]  = 12'd2500;
		v[3]  = 12'd1000;
		v[4]  = 12'd500;
		v[5]  = 12'd200;
		v[28] = 12'd1500;
		v[29] = 12'd3000;
		v[30] = 12'd2049;
		v[31] = 12'd4095;
		push_frame(v, NUM_SENSORS);
		v[0] = '0;
		push_frame(v, 1);
	endtask

	initial begin
		logic [CFG_W-1:0] thr_set  [NUM_PHASES];
		logic [CFG_W-1:0] mult_set [NUM_PHASES];
		thr_set[0]  = 12'd0;
		mult_set[0] = 12'd1;
		thr_set[1]  = 12'd4095;
		mult_set[1] = 12'd4095;
		thr_set[2]  = CFG_W'($urandom_range(4095, 0));
		mult_set[2] = 12'd0;
		thr_set[3]  = CFG_W'($urandom_range(3000, 1000));
		mult_set[3] = 12'd4095;
		thr_set[4]  = CFG_W'($urandom_range(4095, 0));
		mult_set[4] = CFG_W'($urandom_range(2048, 1));
		thr_set[5]  = THR_RESET;
		mult_set[5] = MULT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		queue_directed();
		wait_drained();
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_reg(REG_THRESHOLD, thr_set[p]);
			write_reg(REG_MULT, mult_set[p]);
			queue_random_frames(RANDOM_ITEMS / NUM_PHASES);
			wait_drained();
		end
		$display("Ran %0d frames (%0d samples) over %0d register settings plus reset values",
			frames_sent, samples_in, NUM_PHASES);
		$display("Checked %0d result words, %0d with a line, %0d mismatches",
			results_seen, lines_found, mismatches);
		if (mismatches == 0)
			$display("line_sensor_centroid_top verification clean");
		else
			$display("line_sensor_centroid_top verification failed");
		$finish;
	end

endmodule
